>>> rtl/gregorian_date_difference_unit_assert.svh
// assertion macros shared by the date difference rtl
`ifndef GREGORIAN_DATE_DIFFERENCE_UNIT_ASSERT_SVH
`define GREGORIAN_DATE_DIFFERENCE_UNIT_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define GDD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, disabled while reset is low
`define GDD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> rtl/gdd_pkg.sv
// shared types, constants and tables for the date difference pipeline
package gdd_pkg;

  localparam int unsigned DayW   = 5;
  localparam int unsigned MonthW = 4;
  localparam int unsigned YearW  = 14;
  localparam int unsigned CountW = 22;
  // day numbers reach about 6.0e6 for the largest year field
  localparam int unsigned NumW   = 23;
  localparam int unsigned QuotW  = 8;   // year / 100 for a 14-bit year
  localparam int unsigned OffW   = 9;   // start of month within a march-based year
  localparam int unsigned NumStages = 4;

  // year / 100 as (year * 5243) >> 19, exact for every 14-bit year
  localparam int unsigned Div100Mul   = 5243;
  localparam int unsigned Div100Shift = 19;
  localparam int unsigned ProdW       = 27;

  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  localparam logic [MonthW-1:0] MonthJan = 4'd1;
  localparam logic [MonthW-1:0] MonthFeb = 4'd2;
  localparam logic [MonthW-1:0] MonthDec = 4'd12;

  typedef struct packed {
    logic [DayW-1:0]   first_day;
    logic [MonthW-1:0] first_month;
    logic [YearW-1:0]  first_year;
    logic [DayW-1:0]   second_day;
    logic [MonthW-1:0] second_month;
    logic [YearW-1:0]  second_year;
  } in_beat_t;

  typedef struct packed {
    logic [CountW-1:0] day_count;
    logic              dates_valid;
  } out_beat_t;

  // per-stage pipeline control
  typedef struct packed {
    logic [NumStages-1:0] load;
    logic [NumStages-1:0] valid;
  } ctrl_t;

  // days in a month, month assumed 1..12
  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] month,
                                                 input logic leap);
    logic [DayW-1:0] len;
    case (month)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  // days before the month in a year that starts in march
  function automatic logic [OffW-1:0] month_offset(input logic [MonthW-1:0] month);
    logic [OffW-1:0] off;
    case (month)
      4'd3:    off = 9'd0;
      4'd4:    off = 9'd31;
      4'd5:    off = 9'd61;
      4'd6:    off = 9'd92;
      4'd7:    off = 9'd122;
      4'd8:    off = 9'd153;
      4'd9:    off = 9'd184;
      4'd10:   off = 9'd214;
      4'd11:   off = 9'd245;
      4'd12:   off = 9'd275;
      4'd1:    off = 9'd306;
      4'd2:    off = 9'd337;
      default: off = 9'd0;
    endcase
    return off;
  endfunction

endpackage

>>> rtl/gdd_pipe_ctrl.sv
// valid bits and per-stage load enables with bubble collapsing
module gdd_pipe_ctrl import gdd_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output ctrl_t ctrl_o
);

  logic [NumStages-1:0] valid_q, valid_d;
  logic [NumStages-1:0] load;

  // a stage loads when empty or when its content moves on
  always_comb begin
    load[NumStages-1] = !valid_q[NumStages-1] || out_ready_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      load[k] = !valid_q[k] || load[k+1];
    end
  end

  // valid bits follow the data
  always_comb begin
    valid_d = valid_q;
    if (load[0]) begin
      valid_d[0] = in_valid_i;
    end
    for (int k = 1; k < NumStages; k++) begin
      if (load[k]) begin
        valid_d[k] = valid_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_ready_o   = load[0];
  assign out_valid_o  = valid_q[NumStages-1];
  assign ctrl_o.load  = load;
  assign ctrl_o.valid = valid_q;

endmodule

>>> rtl/gdd_day_number.sv
// three-stage check and day-number pipeline for one date
module gdd_day_number import gdd_pkg::*; #(
  parameter int unsigned MinYear = 1582,
  parameter int unsigned MaxYear = 9999
) (
  input  logic              clk_i,
  input  ctrl_t             ctrl_i,
  input  logic [DayW-1:0]   day_i,
  input  logic [MonthW-1:0] month_i,
  input  logic [YearW-1:0]  year_i,
  output logic              ok_o,
  output logic [NumW-1:0]   num_o
);

  // stage 0: capture date and year / 100
  logic [DayW-1:0]   day_q;
  logic [MonthW-1:0] month_q;
  logic [YearW-1:0]  year_q;
  logic [QuotW-1:0]  quot_q;
  logic [ProdW-1:0]  prod;

  assign prod = ProdW'(year_i) * ProdW'(Div100Mul);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load[0]) begin
      day_q   <= day_i;
      month_q <= month_i;
      year_q  <= year_i;
      quot_q  <= prod[Div100Shift +: QuotW];
    end
  end

  // stage 1: leap year, range checks, march-based year and month offset
  logic [YearW:0]    hund;
  logic [6:0]        rem;
  logic              leap;
  logic              early;
  logic              ok_d;
  logic [YearW-1:0]  yy_d;
  logic [QuotW-1:0]  qq_d;
  logic [OffW:0]     offd_d;
  logic              ok1_q;
  logic [YearW-1:0]  yy_q;
  logic [QuotW-1:0]  qq_q;
  logic [OffW:0]     offd_q;

  always_comb begin
    hund   = {1'b0, year_q} - (YearW + 1)'(quot_q) * (YearW + 1)'(100);
    rem    = hund[6:0];
    leap   = (year_q[1:0] == 2'b00) && ((rem != 7'd0) || (quot_q[1:0] == 2'b00));
    early  = (month_q <= MonthFeb);
    ok_d   = (year_q >= YearW'(MinYear)) && (year_q <= YearW'(MaxYear))
          && (month_q >= MonthJan) && (month_q <= MonthDec)
          && (day_q != '0) && (day_q <= month_len(month_q, leap));
    yy_d   = early ? year_q - YearW'(1) : year_q;
    // a january or february date in a century year steps back one century
    qq_d   = (early && (rem == 7'd0)) ? quot_q - QuotW'(1) : quot_q;
    offd_d = (OffW + 1)'(month_offset(month_q)) + (OffW + 1)'(day_q);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load[1]) begin
      ok1_q  <= ok_d;
      yy_q   <= yy_d;
      qq_q   <= qq_d;
      offd_q <= offd_d;
    end
  end

  // stage 2: closed-form day number
  logic [NumW-1:0] num_d;
  logic            ok2_q;
  logic [NumW-1:0] num_q;

  assign num_d = NumW'(yy_q) * NumW'(365) + NumW'(yy_q >> 2) + NumW'(qq_q >> 2)
               + NumW'(offd_q) - NumW'(qq_q);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load[2]) begin
      ok2_q <= ok1_q;
      num_q <= num_d;
    end
  end

  assign ok_o  = ok2_q;
  assign num_o = num_q;

endmodule

>>> rtl/gregorian_date_difference_unit.sv
// top level: days between two gregorian dates, four-stage pipeline
//
// Input channel: in_valid_i / in_ready_o carry one beat holding two dates
// (day, month, year each). Output channel: out_valid_o / out_ready_i carry
// one beat with the absolute day count and a flag that both dates passed
// the check (year MIN_YEAR..MAX_YEAR, month 1..12, day within the month).
// A failed check gives a count of 0 with the flag clear.
// Every input beat yields exactly one output beat, in order.
// An accepted beat passes through the four register stages (year / 100 product,
// date check, day number, difference and output register) before out_valid_o
// rises; while the receiver does not stall, the block takes one beat per cycle.
// Each stage loads whenever it is empty or its content moves on, so when
// the receiver stalls the pipe fills its empty stages and in_ready_o drops
// only once all four stages hold beats. Nothing is lost or repeated.
// Reset clears all valid bits; the block takes a beat in the first cycle
// after reset is released.
`include "gregorian_date_difference_unit_assert.svh"
module gregorian_date_difference_unit import gdd_pkg::*; #(
  parameter int unsigned MAX_YEAR = 9999,
  parameter int unsigned MIN_YEAR = 1582
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_beat_t  in_beat_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_beat_t out_beat_o
);

  ctrl_t ctrl;

  gdd_pipe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .ctrl_o      (ctrl)
  );

  logic            ok_first, ok_second;
  logic [NumW-1:0] num_first, num_second;

  gdd_day_number #(
    .MinYear (MIN_YEAR),
    .MaxYear (MAX_YEAR)
  ) u_first (
    .clk_i   (clk_i),
    .ctrl_i  (ctrl),
    .day_i   (in_beat_i.first_day),
    .month_i (in_beat_i.first_month),
    .year_i  (in_beat_i.first_year),
    .ok_o    (ok_first),
    .num_o   (num_first)
  );

  gdd_day_number #(
    .MinYear (MIN_YEAR),
    .MaxYear (MAX_YEAR)
  ) u_second (
    .clk_i   (clk_i),
    .ctrl_i  (ctrl),
    .day_i   (in_beat_i.second_day),
    .month_i (in_beat_i.second_month),
    .year_i  (in_beat_i.second_year),
    .ok_o    (ok_second),
    .num_o   (num_second)
  );

  // stage 3: absolute difference, saturation and output register
  logic [NumW-1:0] diff;
  out_beat_t       out_d, out_q;

  always_comb begin
    diff = (num_first >= num_second) ? num_first - num_second : num_second - num_first;
    out_d.dates_valid = ok_first && ok_second;
    if (!(ok_first && ok_second)) begin
      out_d.day_count = '0;
    end else if (diff > NumW'(CountMax)) begin
      out_d.day_count = CountMax;
    end else begin
      out_d.day_count = diff[CountW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.load[NumStages-1]) begin
      out_q <= out_d;
    end
  end

  assign out_beat_o = out_q;

  // failed check never carries a count
  `GDD_ASSERT_NOW(a_invalid_zero, clk_i, rst_ni,
    out_valid_o && !out_beat_o.dates_valid, out_beat_o.day_count == '0)
  // an accepted beat lands in the first stage
  `GDD_ASSERT_NEXT(a_accept_fills, clk_i, rst_ni,
    in_valid_i && in_ready_o, ctrl.valid[0])
  // back pressure reaches the input only with every stage full
  `GDD_ASSERT_NOW(a_stall_full, clk_i, rst_ni, !in_ready_o, &ctrl.valid)

endmodule

>>> tb/sv/tb.sv
// testbench for the gregorian date difference unit: directed and random date pairs
module tb;
  import gdd_pkg::*;

  localparam int unsigned MaxYear     = 9999;
  localparam int unsigned MinYear     = 1582;
  localparam int unsigned StreamBeats = 400;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  in_beat_t  in_beat_i   = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_beat_t out_beat_o;

  // expected day gaps, oldest first
  out_beat_t   pending_gaps[$];
  out_beat_t   want;
  int unsigned error_count    = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_request   = 0;

  gregorian_date_difference_unit #(
    .MAX_YEAR(MaxYear),
    .MIN_YEAR(MinYear)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_beat_i  (in_beat_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_beat_o (out_beat_o)
  );

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // watchdog
  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

  // calendar arithmetic for the expected day gap
  function automatic bit leap_year(input int unsigned year);
    return ((year % 4 == 0) && (year % 100 != 0)) || (year % 400 == 0);
  endfunction

  function automatic int unsigned month_days(input int unsigned year, input int unsigned month);
    if (month == MonthFeb) begin
      return leap_year(year) ? 29 : 28;
    end
    case (month)
      4, 6, 9, 11: return 30;
      default:     return 31;
    endcase
  endfunction

  function automatic bit date_legal(input int unsigned day, input int unsigned month,
                                    input int unsigned year);
    if (year < MinYear || year > MaxYear) return 1'b0;
    if (month < MonthJan || month > MonthDec) return 1'b0;
    return (day >= 1) && (day <= month_days(year, month));
  endfunction

  // days since a fixed origin, counted from january of year 1
  function automatic int unsigned serial_day(input int unsigned day, input int unsigned month,
                                             input int unsigned year);
    int unsigned prior;
    int unsigned total;
    prior = year - 1;
    total = 365 * prior + prior / 4 - prior / 100 + prior / 400 + day;
    for (int m = 1; m < month; m++) begin
      total += month_days(year, m);
    end
    return total;
  endfunction

  function automatic out_beat_t days_between(input in_beat_t beat);
    out_beat_t   res;
    int unsigned a;
    int unsigned z;
    int unsigned diff;
    res = '0;
    if (date_legal(beat.first_day, beat.first_month, beat.first_year) &&
        date_legal(beat.second_day, beat.second_month, beat.second_year)) begin
      a = serial_day(beat.first_day, beat.first_month, beat.first_year);
      z = serial_day(beat.second_day, beat.second_month, beat.second_year);
      diff = (a > z) ? a - z : z - a;
      if (diff > CountMax) diff = CountMax;
      res.day_count   = diff[CountW-1:0];
      res.dates_valid = 1'b1;
    end
    return res;
  endfunction

  // stimulus helpers
  function automatic in_beat_t date_pair(input int unsigned d1, input int unsigned m1,
                                         input int unsigned y1, input int unsigned d2,
                                         input int unsigned m2, input int unsigned y2);
    in_beat_t beat;
    beat.first_day    = d1[DayW-1:0];
    beat.first_month  = m1[MonthW-1:0];
    beat.first_year   = y1[YearW-1:0];
    beat.second_day   = d2[DayW-1:0];
    beat.second_month = m2[MonthW-1:0];
    beat.second_year  = y2[YearW-1:0];
    return beat;
  endfunction

  // legal date packed as day, month, year
  function automatic logic [DayW+MonthW+YearW-1:0] legal_date();
    int unsigned y;
    int unsigned m;
    int unsigned d;
    case ($urandom_range(9))
      0:       y = MinYear + $urandom_range(3);
      1:       y = MaxYear - $urandom_range(3);
      2:       y = 400 * $urandom_range(24, 4);
      3:       y = 100 * $urandom_range(99, 16);
      default: y = $urandom_range(MaxYear, MinYear);
    endcase
    m = $urandom_range(12, 1);
    if ($urandom_range(3) == 0) d = month_days(y, m);
    else d = $urandom_range(month_days(y, m), 1);
    return {d[DayW-1:0], m[MonthW-1:0], y[YearW-1:0]};
  endfunction

  // legal date with one field pushed out of range
  function automatic logic [DayW+MonthW+YearW-1:0] broken_date();
    logic [DayW-1:0]   d;
    logic [MonthW-1:0] m;
    logic [YearW-1:0]  y;
    int unsigned       len;
    {d, m, y} = legal_date();
    case ($urandom_range(4))
      0: d = '0;
      1: begin
        len = month_days(y, m) + 1;
        d = len[DayW-1:0];
      end
      2: m = ($urandom_range(1) == 0) ? '0 : MonthW'(MonthDec + $urandom_range(3, 1));
      3: y = YearW'($urandom_range(MinYear - 1, 0));
      default: y = YearW'($urandom_range(16383, MaxYear + 1));
    endcase
    return {d, m, y};
  endfunction

  function automatic in_beat_t random_pair();
    in_beat_t    beat;
    logic [63:0] raw;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 72) begin
      {beat.first_day, beat.first_month, beat.first_year} = legal_date();
      {beat.second_day, beat.second_month, beat.second_year} = legal_date();
      if (pick < 7) begin
        beat.second_day   = beat.first_day;
        beat.second_month = beat.first_month;
        beat.second_year  = beat.first_year;
      end
    end else if (pick < 90) begin
      {beat.first_day, beat.first_month, beat.first_year} = legal_date();
      {beat.second_day, beat.second_month, beat.second_year} = broken_date();
      if (pick < 81) begin
        beat = {beat[DayW+MonthW+YearW-1:0], beat[$bits(in_beat_t)-1:DayW+MonthW+YearW]};
      end
    end else begin
      raw = {$urandom(), $urandom()};
      beat = raw[$bits(in_beat_t)-1:0];
    end
    return beat;
  endfunction

  // one line per mismatch
  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    error_count++;
  endtask

  // offer one beat, holding it until accepted
  task automatic send_beat(input in_beat_t beat);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_beat_i  <= beat;
    do @(posedge clk_i); while (!in_ready_o);
    pending_gaps.push_back(days_between(beat));
  endtask

  // drop valid and let every expected beat come out
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_gaps.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // receiver ready, with random stalls and requested hold-offs
  initial begin : rx_ready_drive
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // compare each result beat with the oldest expected one
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_gaps.size() == 0) begin
        report_mismatch("result beat with no expected result waiting");
      end else begin
        want = pending_gaps.pop_front();
        if (out_beat_o.day_count !== want.day_count)
          report_mismatch($sformatf("day_count got %0d want %0d",
                                    out_beat_o.day_count, want.day_count));
        if (out_beat_o.dates_valid !== want.dates_valid)
          report_mismatch($sformatf("dates_valid got %b want %b",
                                    out_beat_o.dates_valid, want.dates_valid));
      end
    end
  end

  // field extremes, leap rules and each invalid case
  task automatic test_directed();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_beat(date_pair(1, 1, MinYear, 1, 1, MinYear));
    send_beat(date_pair(1, 1, MinYear, 31, 12, MaxYear));
    send_beat(date_pair(31, 12, MaxYear, 1, 1, MinYear));
    send_beat(date_pair(29, 2, 2000, 1, 3, 2000));
    send_beat(date_pair(29, 2, 1900, 1, 1, 1900));
    send_beat(date_pair(29, 2, 2004, 28, 2, 2005));
    send_beat(date_pair(29, 2, 2001, 1, 3, 2001));
    send_beat(date_pair(31, 12, MinYear - 1, 1, 1, 2000));
    send_beat(date_pair(1, 1, MaxYear + 1, 1, 1, 2000));
    send_beat(date_pair(31, 15, 16383, 31, 15, 16383));
    send_beat(date_pair(0, 0, 0, 0, 0, 0));
    send_beat(date_pair(1, 0, 2000, 1, 1, 2000));
    send_beat(date_pair(1, 13, 2000, 1, 1, 2000));
    send_beat(date_pair(0, 6, 2000, 1, 6, 2000));
    send_beat(date_pair(31, 4, 2020, 1, 5, 2020));
    send_beat(date_pair(31, 12, 2020, 1, 1, 2021));
    send_beat(date_pair(1, 3, 1600, 28, 2, 1700));
    send_beat(date_pair(15, 10, MinYear, 1, 1, MaxYear + 1));
    send_beat(date_pair(30, 9, 1999, 1, 10, 1999));
    send_beat(date_pair(1, 1, MaxYear, 1, 1, MinYear + 1));
    send_beat(date_pair(28, 2, 2100, 29, 2, 2400));
    drain();
  endtask

  // random date pairs under one idling mix
  task automatic test_stream(input int unsigned idle_pct, input int unsigned stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (StreamBeats) send_beat(random_pair());
    drain();
  endtask

  // long receiver hold-off while the sender keeps offering beats
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = 64;
    repeat (24) send_beat(random_pair());
    recv_stall_pct = 30;
    hold_request   = 40;
    repeat (24) send_beat(random_pair());
    drain();
  endtask

  // reset, tests in turn, verdict
  initial begin : main
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_stream(0, 0);
    test_stream(49, 0);
    test_stream(0, 49);
    test_stream(19, 19);
    test_backpressure();
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
